[hdl/fbd_pkg.sv]
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types and constants for the frame body deframer.
// ----------------------------------------------------------------------------
package fbd_pkg;

    // One byte of the received buffer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } byte_t;

    // One result item: a payload byte or a frame status.
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_value;
        logic [15:0] payload_position;
        logic [7:0]  command_code;
        logic [15:0] declared_length;
        logic [7:0]  received_check;
        logic        check_matches;
        logic [1:0]  frame_status;
    } result_t;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes.
    localparam logic [1:0] STATUS_COMPLETE    = 2'd0;
    localparam logic [1:0] STATUS_ZERO_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_ENDED_EARLY = 2'd2;

    // The checksum byte equals this seed minus the byte sum, modulo 256.
    localparam logic [7:0] CHECK_SEED = 8'hAA;

endpackage

[hdl/frame_body_deframer_top.sv]
// ----------------------------------------------------------------------------
// frame_body_deframer_top
// Deframer for length-prefixed frames with an additive checksum.
//
//   Channel   Handshake                    Payload
//   bytes     byte_valid / byte_stall      byte_data   (fbd_pkg::byte_t)
//   results   result_valid / result_stall  result_data (fbd_pkg::result_t)
//
// One byte is taken per cycle while byte_stall is low. A byte passes through the
// input register, the parser and the result register before its result is offered.
// The rate is set by the input register feeding the result register through
// the combinational parser. Reset empties both registers and returns the parser
// to the command byte. A stalled result holds the result register; a byte with
// no result still drains while the output is stalled.
// ----------------------------------------------------------------------------
module frame_body_deframer_top
    import fbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    byte_valid,
    output logic    byte_stall,
    input  byte_t   byte_data,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    logic    in_full;
    byte_t   in_item;
    logic    advance;
    logic    has_result;
    result_t parse_result;
    logic    out_free;

    // The held byte moves on unless its result has nowhere to go.
    assign advance = in_full && (!has_result || out_free);

    fbd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .advance    (advance),
        .full       (in_full),
        .item       (in_item)
    );

    fbd_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (in_item),
        .advance    (advance),
        .has_result (has_result),
        .result     (parse_result)
    );

    fbd_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && has_result),
        .load_item    (parse_result),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

[hdl/fbd_in_reg.sv]
// ----------------------------------------------------------------------------
// fbd_in_reg
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module fbd_in_reg
    import fbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  byte_valid,
    output logic  byte_stall,
    input  byte_t byte_data,
    input  logic  advance,
    output logic  full,
    output byte_t item
);

    logic  full_reg;
    logic  full_next;
    byte_t item_reg;
    logic  take;

    // The register takes a new byte whenever it is empty or drains this cycle.
    assign byte_stall = full_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        full_next = full_reg;
        if (take)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Held byte; needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= byte_data;
        end
    end

    assign full = full_reg;
    assign item = item_reg;

endmodule

[hdl/fbd_parse.sv]
// ----------------------------------------------------------------------------
// fbd_parse
// Frame parser: tracks the position within the frame and forms the result
// for the byte held in the input register.
// ----------------------------------------------------------------------------
module fbd_parse
    import fbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  byte_t   item,
    input  logic    advance,
    output logic    has_result,
    output result_t result
);

    typedef enum logic [2:0] {
        PH_CMD   = 3'd0,
        PH_LENLO = 3'd1,
        PH_LENHI = 3'd2,
        PH_PAY   = 3'd3,
        PH_CHK   = 3'd4,
        PH_SKIP  = 3'd5
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  command_reg;
    logic [7:0]  command_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [15:0] counter_reg;
    logic [15:0] counter_next;

    logic [7:0]  b;
    logic        last;
    logic [15:0] full_length;
    logic [7:0]  expected_check;

    assign b              = item.data_byte;
    assign last           = item.end_of_buffer;
    assign full_length    = {b, length_reg[7:0]};
    assign expected_check = CHECK_SEED - sum_reg;

    // Next state and result for the byte held in the input register.
    always_comb
    begin
        phase_next     = phase_reg;
        command_next   = command_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        counter_next   = counter_reg;
        has_result     = 1'b0;
        result         = '0;
        result.result_kind = KIND_STATUS;

        unique case (phase_reg)
            PH_LENLO:
            begin
                length_next = {8'd0, b};
                sum_next    = sum_reg + b;
                if (last)
                begin
                    phase_next          = PH_CMD;
                    has_result          = 1'b1;
                    result.frame_status = STATUS_ENDED_EARLY;
                end
                else
                begin
                    phase_next = PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                length_next = full_length;
                sum_next    = sum_reg + b;
                if (last)
                begin
                    phase_next          = PH_CMD;
                    has_result          = 1'b1;
                    result.frame_status = STATUS_ENDED_EARLY;
                end
                else if (full_length == 16'd0)
                begin
                    phase_next          = PH_SKIP;
                    has_result          = 1'b1;
                    result.frame_status = STATUS_ZERO_LENGTH;
                end
                else
                begin
                    remaining_next = full_length - 16'd1;
                    phase_next     = (full_length == 16'd1) ? PH_CHK : PH_PAY;
                end
            end
            PH_PAY:
            begin
                has_result = 1'b1;
                if (last)
                begin
                    // A flagged byte here means the checksum never arrived.
                    phase_next          = PH_CMD;
                    result.frame_status = STATUS_ENDED_EARLY;
                end
                else
                begin
                    result.result_kind      = KIND_PAYLOAD;
                    result.payload_value    = b;
                    result.payload_position = counter_reg;
                    sum_next       = sum_reg + b;
                    counter_next   = counter_reg + 16'd1;
                    remaining_next = remaining_reg - 16'd1;
                    if (remaining_reg == 16'd1)
                    begin
                        phase_next = PH_CHK;
                    end
                end
            end
            PH_CHK:
            begin
                phase_next             = last ? PH_CMD : PH_SKIP;
                has_result             = 1'b1;
                result.frame_status    = STATUS_COMPLETE;
                result.command_code    = command_reg;
                result.declared_length = length_reg;
                result.received_check  = b;
                result.check_matches   = (b == expected_check);
            end
            PH_SKIP:
            begin
                if (last)
                begin
                    phase_next = PH_CMD;
                end
            end
            default:
            begin
                // Command byte; unused phase codes act the same way.
                command_next   = b;
                length_next    = 16'd0;
                remaining_next = 16'd0;
                sum_next       = b;
                counter_next   = 16'd0;
                if (last)
                begin
                    phase_next          = PH_CMD;
                    has_result          = 1'b1;
                    result.frame_status = STATUS_ENDED_EARLY;
                end
                else
                begin
                    phase_next = PH_LENLO;
                end
            end
        endcase
    end

    // Frame state, updated when the held byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            command_reg   <= 8'd0;
            length_reg    <= 16'd0;
            remaining_reg <= 16'd0;
            sum_reg       <= 8'd0;
            counter_reg   <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            command_reg   <= command_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            counter_reg   <= counter_next;
        end
    end

endmodule

[hdl/fbd_out_reg.sv]
// ----------------------------------------------------------------------------
// fbd_out_reg
// Result register: holds one result until the receiving side takes it.
// ----------------------------------------------------------------------------
module fbd_out_reg
    import fbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_item,
    output logic    free,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can be loaded when empty or when its result leaves now.
    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload; needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_item;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule
